### rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque with delete-by-value.
package bdq_pkg;

  localparam logic [3:0] REQ_ADD_FRONT  = 4'd0;
  localparam logic [3:0] REQ_ADD_BACK   = 4'd1;
  localparam logic [3:0] REQ_DEL_FRONT  = 4'd2;
  localparam logic [3:0] REQ_DEL_BACK   = 4'd3;
  localparam logic [3:0] REQ_DEL_VALUE  = 4'd4;
  localparam logic [3:0] REQ_CLEAR      = 4'd5;
  localparam logic [3:0] REQ_READ_ALL   = 4'd6;
  localparam logic [3:0] REQ_READ_FIRST = 4'd7;
  localparam logic [3:0] REQ_READ_LAST  = 4'd8;

  localparam logic [2:0] KIND_ENTRY   = 3'd0;
  localparam logic [2:0] KIND_DONE    = 3'd1;
  localparam logic [2:0] KIND_EMPTY   = 3'd2;
  localparam logic [2:0] KIND_FULL    = 3'd3;
  localparam logic [2:0] KIND_MISSING = 3'd4;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] item_value;
    logic [15:0]        how_many;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [2:0]         result_kind;
    logic               last_flag;
  } rsp_t;

  typedef struct packed {
    logic       latch_req;
    logic       add_front;
    logic       add_back;
    logic       del_front;
    logic       shrink;
    logic       clear;
    logic       search_setup;
    logic       read_setup;
    logic       mem_rd;
    logic       rd_next;
    logic       shift_wr;
    logic       pos_inc;
    logic       set_kind;
    logic [2:0] kind;
    logic       emit_entry;
    logic       emit_status;
  } cmd_t;

  typedef struct packed {
    logic [3:0] req_type;
    logic       empty;
    logic       full;
    logic       n_zero;
    logic       match;
    logic       pos_at_last;
    logic       pos_at_end;
    logic       out_free;
  } stat_t;

endpackage

### rtl/bdq_ctrl.sv
// Request sequencer: decodes a transaction and steps the datapath through it.
module bdq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bdq_pkg::stat_t stat,
  output bdq_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SRCH_RD  = 3'd2;
  localparam logic [2:0] S_SRCH_CMP = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_RD_ISSUE = 3'd6;
  localparam logic [2:0] S_RD_EMIT  = 3'd7;

  logic [2:0] state, state_next;
  logic       in_stat, in_stat_next;

  assign req_ready = (state == S_IDLE) && !in_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_stat <= 1'b0;
    end else begin
      state   <= state_next;
      in_stat <= in_stat_next;
    end
  end

  always_comb begin
    cmd          = '0;
    state_next   = state;
    in_stat_next = in_stat;
    if (in_stat) begin
      // status result pending
      if (stat.out_free) begin
        cmd.emit_status = 1'b1;
        in_stat_next    = 1'b0;
        state_next      = S_IDLE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd.latch_req = 1'b1;
            state_next    = S_DECODE;
          end
        end
        S_DECODE: begin
          cmd.set_kind = 1'b1;
          cmd.kind     = bdq_pkg::KIND_DONE;
          in_stat_next = 1'b1;
          state_next   = S_IDLE;
          unique case (stat.req_type)
            bdq_pkg::REQ_ADD_FRONT: begin
              if (stat.full) cmd.kind = bdq_pkg::KIND_FULL;
              else cmd.add_front = 1'b1;
            end
            bdq_pkg::REQ_ADD_BACK: begin
              if (stat.full) cmd.kind = bdq_pkg::KIND_FULL;
              else cmd.add_back = 1'b1;
            end
            bdq_pkg::REQ_DEL_FRONT: begin
              if (stat.empty) cmd.kind = bdq_pkg::KIND_EMPTY;
              else cmd.del_front = 1'b1;
            end
            bdq_pkg::REQ_DEL_BACK: begin
              if (stat.empty) cmd.kind = bdq_pkg::KIND_EMPTY;
              else cmd.shrink = 1'b1;
            end
            bdq_pkg::REQ_DEL_VALUE: begin
              if (stat.empty) begin
                cmd.kind = bdq_pkg::KIND_EMPTY;
              end else begin
                cmd.set_kind     = 1'b0;
                cmd.search_setup = 1'b1;
                in_stat_next     = 1'b0;
                state_next       = S_SRCH_RD;
              end
            end
            bdq_pkg::REQ_CLEAR: begin
              cmd.clear = 1'b1;
            end
            bdq_pkg::REQ_READ_ALL, bdq_pkg::REQ_READ_FIRST,
            bdq_pkg::REQ_READ_LAST: begin
              cmd.read_setup = 1'b1;
              if (stat.n_zero) begin
                cmd.kind = bdq_pkg::KIND_EMPTY;
              end else begin
                cmd.set_kind = 1'b0;
                in_stat_next = 1'b0;
                state_next   = S_RD_ISSUE;
              end
            end
            default: begin
              cmd.kind = bdq_pkg::KIND_EMPTY;
            end
          endcase
        end
        S_SRCH_RD: begin
          cmd.mem_rd = 1'b1;
          state_next = S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (stat.match) begin
            state_next = S_SHIFT_RD;
          end else if (stat.pos_at_last) begin
            cmd.set_kind = 1'b1;
            cmd.kind     = bdq_pkg::KIND_MISSING;
            in_stat_next = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.pos_inc = 1'b1;
            state_next  = S_SRCH_RD;
          end
        end
        S_SHIFT_RD: begin
          if (stat.pos_at_last) begin
            cmd.shrink   = 1'b1;
            cmd.set_kind = 1'b1;
            cmd.kind     = bdq_pkg::KIND_DONE;
            in_stat_next = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_next = 1'b1;
            state_next  = S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          cmd.shift_wr = 1'b1;
          cmd.pos_inc  = 1'b1;
          state_next   = S_SHIFT_RD;
        end
        S_RD_ISSUE: begin
          cmd.mem_rd = 1'b1;
          state_next = S_RD_EMIT;
        end
        S_RD_EMIT: begin
          if (stat.out_free) begin
            cmd.emit_entry = 1'b1;
            cmd.pos_inc    = 1'b1;
            state_next     = stat.pos_at_end ? S_IDLE : S_RD_ISSUE;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/bdq_dpath.sv
// Datapath: circular entry store, front/count pointers, walk counter, output register.
module bdq_dpath #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  bdq_pkg::req_t  req,
  input  bdq_pkg::cmd_t  cmd,
  output bdq_pkg::stat_t stat,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bdq_pkg::rsp_t  rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  bdq_pkg::req_t      req_q;
  logic [IW-1:0]      front;
  logic [CW-1:0]      count;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      end_pos;
  logic [2:0]         kind;

  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      raddr;
  logic [IW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               mem_we;
  logic [CW-1:0]      n_sel;
  logic [CW-1:0]      start_sel;
  logic [CW:0]        pos_p1;
  logic [15:0]        count_ext;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [CW:0] off);
    logic [CW+1:0] sum;
    sum = (CW+2)'(base) + (CW+2)'(off);
    if (sum >= (CW+2)'(CAPACITY)) sum = sum - (CW+2)'(CAPACITY);
    return sum[IW-1:0];
  endfunction

  assign front_dec = (front == '0) ? IW'(CAPACITY - 1) : front - 1'b1;
  assign pos_p1    = (CW+1)'(pos) + 1'b1;
  assign raddr     = slot(front, cmd.rd_next ? pos_p1 : (CW+1)'(pos));
  assign count_ext = 16'(count);

  always_comb begin
    mem_we = cmd.add_front | cmd.add_back | cmd.shift_wr;
    wdata  = cmd.shift_wr ? rdata : req_q.item_value;
    priority if (cmd.add_front) waddr = front_dec;
    else if (cmd.add_back)      waddr = slot(front, (CW+1)'(count));
    else                        waddr = slot(front, (CW+1)'(pos));
  end

  always_comb begin
    if (req_q.req_type == bdq_pkg::REQ_READ_ALL) n_sel = count;
    else if (req_q.how_many < count_ext)         n_sel = req_q.how_many[CW-1:0];
    else                                         n_sel = count;
    start_sel = (req_q.req_type == bdq_pkg::REQ_READ_LAST) ? count - n_sel : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata <= mem[raddr];
    if (cmd.latch_req) req_q <= req;
    if (cmd.set_kind) kind <= cmd.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      priority if (cmd.clear) begin
        front <= '0;
        count <= '0;
      end else if (cmd.add_front) begin
        front <= front_dec;
        count <= count + 1'b1;
      end else if (cmd.add_back) begin
        count <= count + 1'b1;
      end else if (cmd.del_front) begin
        front <= slot(front, (CW+1)'(1));
        count <= count - 1'b1;
      end else if (cmd.shrink) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.search_setup) begin
      pos <= '0;
    end else if (cmd.read_setup) begin
      pos     <= start_sel;
      end_pos <= start_sel + n_sel;
    end else if (cmd.pos_inc) begin
      pos <= pos_p1[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_entry || cmd.emit_status) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_entry) begin
      rsp.out_value   <= rdata;
      rsp.result_kind <= bdq_pkg::KIND_ENTRY;
      rsp.last_flag   <= (pos_p1 == (CW+1)'(end_pos));
    end else if (cmd.emit_status) begin
      rsp.out_value   <= '0;
      rsp.result_kind <= kind;
      rsp.last_flag   <= 1'b1;
    end
  end

  assign stat.req_type    = req_q.req_type;
  assign stat.empty       = (count == '0);
  assign stat.full        = (count == CW'(CAPACITY));
  assign stat.n_zero      = (n_sel == '0);
  assign stat.match       = (rdata == req_q.item_value);
  assign stat.pos_at_last = (pos_p1 == (CW+1)'(count));
  assign stat.pos_at_end  = (pos_p1 == (CW+1)'(end_pos));
  assign stat.out_free    = !rsp_valid || rsp_ready;

endmodule

### rtl/bounded_deque_with_value_delete.sv
// Top level of the bounded deque with delete-by-value.
// Holds up to CAPACITY signed 32-bit entries in a circular single-port store with a
// registered read. One request is handled at a time; a new request is taken once the
// previous one has produced all of its results into the output register (the last result
// may still be waiting there). Add, delete front/back and clear act on the pointers and
// then return a status result. Reads fetch each entry from the store before emitting it
// and wait while the output register is still full. Delete by value walks the store,
// first searching and then shifting; search and shift together touch each entry once.
// Each step waits on the store's single read port with its registered output.
module bounded_deque_with_value_delete #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bdq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bdq_pkg::rsp_t rsp
);

  bdq_pkg::cmd_t  cmd;
  bdq_pkg::stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### verif/tb_top.sv
// Self-checking testbench for the bounded deque: directed table, random traffic, scoreboard.
module tb_top;

  localparam int CAPACITY    = 32;
  localparam int HALF_PERIOD = 5;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 4 * CAPACITY + 16;
  localparam int N_DIRECTED  = 24;
  localparam int N_SEGMENTS  = 7;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

  typedef struct packed {
    bdq_pkg::req_t txn;
    logic          typed;
    logic [2:0]    kind;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  bdq_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  bdq_pkg::rsp_t rsp;

  logic signed [31:0] dq_store [CAPACITY];
  int            dq_front = 0;
  int            dq_count = 0;
  bdq_pkg::rsp_t pending_results [$];
  int            mismatches = 0;
  bit            tx_calm = 1'b0;

  dir_row_t directed [N_DIRECTED] = '{
    '{'{bdq_pkg::REQ_READ_ALL,   32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_DEL_FRONT,  32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_DEL_BACK,   32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_DEL_VALUE,  32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_READ_FIRST, 32'sd0,       16'd5},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_CLEAR,      32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_ADD_FRONT,  32'h7fffffff, 16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_ADD_BACK,   32'h80000000, 16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_ADD_FRONT,  32'hffffffff, 16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_ADD_BACK,   32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_READ_ALL,   32'sd0,       16'd0},    1'b0, bdq_pkg::KIND_ENTRY},
    '{'{bdq_pkg::REQ_READ_FIRST, 32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_READ_FIRST, 32'sd0,       16'd2},    1'b0, bdq_pkg::KIND_ENTRY},
    '{'{bdq_pkg::REQ_READ_LAST,  32'sd0,       16'hffff}, 1'b0, bdq_pkg::KIND_ENTRY},
    '{'{bdq_pkg::REQ_READ_LAST,  32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_DEL_VALUE,  32'sd12345,   16'd0},    1'b1, bdq_pkg::KIND_MISSING},
    '{'{bdq_pkg::REQ_DEL_VALUE,  32'h80000000, 16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{4'hf,                    32'hffffffff, 16'hffff}, 1'b1, bdq_pkg::KIND_EMPTY},
    '{'{4'h9,                    32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY},
    '{'{bdq_pkg::REQ_DEL_FRONT,  32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_DEL_BACK,   32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_READ_LAST,  32'sd0,       16'd1},    1'b0, bdq_pkg::KIND_ENTRY},
    '{'{bdq_pkg::REQ_CLEAR,      32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_DONE},
    '{'{bdq_pkg::REQ_READ_ALL,   32'sd0,       16'd0},    1'b1, bdq_pkg::KIND_EMPTY}
  };

  phase_e seg_phase [N_SEGMENTS] = '{PH_FILL, PH_MIX, PH_DRAIN, PH_FILL, PH_MIX,
                                     PH_FILL, PH_DRAIN};
  int     seg_len   [N_SEGMENTS] = '{40, 30, 40, 40, 30, 30, 40};

  bounded_deque_with_value_delete #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int slot(int pos);
    return (dq_front + pos) % CAPACITY;
  endfunction

  function automatic void push_status(logic [2:0] kind);
    bdq_pkg::rsp_t r;
    r.out_value   = '0;
    r.result_kind = kind;
    r.last_flag   = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void push_entries(int first, int n);
    bdq_pkg::rsp_t r;
    if (n == 0) begin
      push_status(bdq_pkg::KIND_EMPTY);
      return;
    end
    for (int i = 0; i < n; i++) begin
      r.out_value   = dq_store[slot(first + i)];
      r.result_kind = bdq_pkg::KIND_ENTRY;
      r.last_flag   = (i == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  // Updates the deque image and queues the results this transaction must produce.
  function automatic void deque_predict(bdq_pkg::req_t t);
    int pos;
    int n;
    n = (int'(t.how_many) < dq_count) ? int'(t.how_many) : dq_count;
    case (t.req_type)
      bdq_pkg::REQ_ADD_FRONT, bdq_pkg::REQ_ADD_BACK: begin
        if (dq_count >= CAPACITY) begin
          push_status(bdq_pkg::KIND_FULL);
        end else begin
          if (t.req_type == bdq_pkg::REQ_ADD_FRONT) begin
            dq_front = (dq_front + CAPACITY - 1) % CAPACITY;
            dq_store[dq_front] = t.item_value;
          end else begin
            dq_store[slot(dq_count)] = t.item_value;
          end
          dq_count++;
          push_status(bdq_pkg::KIND_DONE);
        end
      end
      bdq_pkg::REQ_DEL_FRONT, bdq_pkg::REQ_DEL_BACK: begin
        if (dq_count == 0) begin
          push_status(bdq_pkg::KIND_EMPTY);
        end else begin
          if (t.req_type == bdq_pkg::REQ_DEL_FRONT) dq_front = slot(1);
          dq_count--;
          push_status(bdq_pkg::KIND_DONE);
        end
      end
      bdq_pkg::REQ_DEL_VALUE: begin
        pos = dq_count;
        for (int i = dq_count - 1; i >= 0; i--)
          if (dq_store[slot(i)] == t.item_value) pos = i;
        if (dq_count == 0) begin
          push_status(bdq_pkg::KIND_EMPTY);
        end else if (pos == dq_count) begin
          push_status(bdq_pkg::KIND_MISSING);
        end else begin
          for (int i = pos; i + 1 < dq_count; i++) dq_store[slot(i)] = dq_store[slot(i + 1)];
          dq_count--;
          push_status(bdq_pkg::KIND_DONE);
        end
      end
      bdq_pkg::REQ_CLEAR: begin
        dq_front = 0;
        dq_count = 0;
        push_status(bdq_pkg::KIND_DONE);
      end
      bdq_pkg::REQ_READ_ALL:   push_entries(0, dq_count);
      bdq_pkg::REQ_READ_FIRST: push_entries(0, n);
      bdq_pkg::REQ_READ_LAST:  push_entries(dq_count - n, n);
      default:                 push_status(bdq_pkg::KIND_EMPTY);
    endcase
  endfunction

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'hffffffff;
          default: return 32'sd0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] draw_count();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 40));
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic bdq_pkg::req_t draw_request(phase_e ph);
    bdq_pkg::req_t t;
    int            roll;
    int            add_lim;
    int            read_lim;
    int            del_lim;
    int            clr_lim;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  begin add_lim = 75; read_lim = 90; del_lim = 96; clr_lim = 96; end
      PH_MIX:   begin add_lim = 30; read_lim = 55; del_lim = 85; clr_lim = 90; end
      default:  begin add_lim = 10; read_lim = 30; del_lim = 95; clr_lim = 95; end
    endcase
    t.item_value = draw_value();
    t.how_many   = draw_count();
    if (roll < add_lim) begin
      t.req_type = 4'(bdq_pkg::REQ_ADD_FRONT + $urandom_range(0, 1));
    end else if (roll < read_lim) begin
      t.req_type = 4'(bdq_pkg::REQ_READ_ALL + $urandom_range(0, 2));
    end else if (roll < del_lim) begin
      case ($urandom_range(0, 3))
        0: t.req_type = bdq_pkg::REQ_DEL_FRONT;
        1: t.req_type = bdq_pkg::REQ_DEL_BACK;
        default: t.req_type = bdq_pkg::REQ_DEL_VALUE;
      endcase
      if (t.req_type == bdq_pkg::REQ_DEL_VALUE && dq_count > 0 && $urandom_range(0, 2) != 0)
        t.item_value = dq_store[slot($urandom_range(0, dq_count - 1))];
    end else if (roll < clr_lim) begin
      t.req_type = bdq_pkg::REQ_CLEAR;
    end else begin
      t.req_type = 4'($urandom_range(9, 15));
    end
    return t;
  endfunction

  // Offers one transaction and predicts its results once it is taken.
  task automatic offer(bdq_pkg::req_t t, logic typed, logic [2:0] kind);
    int            gap;
    bdq_pkg::rsp_t r;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= t;
    do @(posedge clk); while (!req_ready);
    deque_predict(t);
    if (typed) begin
      r.out_value   = '0;
      r.result_kind = kind;
      r.last_flag   = 1'b1;
      pending_results[pending_results.size() - 1] = r;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) offer(directed[i].txn, directed[i].typed, directed[i].kind);
    for (int s = 0; s < N_SEGMENTS; s++) begin
      tx_calm = ($urandom_range(0, 2) == 0);
      if (s == 3) begin
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      for (int i = 0; i < seg_len[s]; i++)
        offer(draw_request(seg_phase[s]), 1'b0, bdq_pkg::KIND_DONE);
    end
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, scoreboard check.
  initial begin
    int            stall;
    int            got;
    bit            rx_calm;
    bdq_pkg::rsp_t want;
    got     = 0;
    rx_calm = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (got % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall = (got == HOLD_AT) ? HOLD_CYCLES : (rx_calm ? 0 : $urandom_range(0, 7));
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      got++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction: value=%0d kind=%0d last=%0d",
                 $time, rsp.out_value, rsp.result_kind, rsp.last_flag);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.out_value !== want.out_value || rsp.result_kind !== want.result_kind ||
            rsp.last_flag !== want.last_flag) begin
          $display("%0t: mismatch: expected value=%0d kind=%0d last=%0d,",
                   $time, want.out_value, want.result_kind, want.last_flag);
          $display("%0t:           got value=%0d kind=%0d last=%0d",
                   $time, rsp.out_value, rsp.result_kind, rsp.last_flag);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(2 * HALF_PERIOD * 600000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_dpath.sv
rtl/bounded_deque_with_value_delete.sv
verif/tb_top.sv
